// ----- design/gfmix_pkg.sv -----
// Types, constants and GF(2^8) multiply shared by the column mix block.
`timescale 1ns / 1ps
`default_nettype none
package gfmix_pkg;

  localparam int unsigned MIX_BYTES   = 8;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned COL_W       = MIX_BYTES * BYTE_W;
  localparam int unsigned CFG_INDEX_W = $clog2(MIX_BYTES);

  localparam logic [BYTE_W-1:0] GF_POLY_LOW = 8'h1d;
  localparam logic [BYTE_W-1:0] GF_MSB      = 8'h80;

  typedef logic [COL_W-1:0]                 column_t;
  typedef logic [MIX_BYTES-1:0][COL_W-1:0] matrix_t;
  typedef logic [CFG_INDEX_W-1:0]           cfg_index_t;

  typedef struct packed {
    column_t column_in;
    logic    last_column;
  } in_req_t;

  typedef struct packed {
    column_t column_out;
    logic    last;
  } out_req_t;

  function automatic logic [BYTE_W-1:0] gf_mul(
    input logic [BYTE_W-1:0] x_in,
    input logic [BYTE_W-1:0] y_in
  );
    logic [BYTE_W-1:0] x;
    logic [BYTE_W-1:0] acc;
    x   = x_in;
    acc = '0;
    for (int k = 0; k < BYTE_W; k++) begin
      if (y_in[k]) begin
        acc = acc ^ x;
      end
      if ((x & GF_MSB) != '0) begin
        x = {x[BYTE_W-2:0], 1'b0} ^ GF_POLY_LOW;
      end else begin
        x = {x[BYTE_W-2:0], 1'b0};
      end
    end
    return acc;
  endfunction

endpackage
`default_nettype wire

// ----- design/gfmix_regs.sv -----
// Matrix row registers written through the configuration port.
`timescale 1ns / 1ps
`default_nettype none
module gfmix_regs (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_valid,
  input  wire gfmix_pkg::cfg_index_t cfg_index,
  input  wire gfmix_pkg::column_t    cfg_data,
  output gfmix_pkg::matrix_t         matrix
);
  import gfmix_pkg::*;

  matrix_t matrix_r;
  matrix_t matrix_nxt;

  always_comb begin
    matrix_nxt = matrix_r;
    if (cfg_valid) begin
      matrix_nxt[cfg_index] = cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      matrix_r <= '0;
    end else begin
      matrix_r <= matrix_nxt;
    end
  end

  assign matrix = matrix_r;

endmodule
`default_nettype wire

// ----- design/gfmix_mix.sv -----
// Combinational GF(2^8) matrix-by-column product.
`timescale 1ns / 1ps
`default_nettype none
module gfmix_mix (
  input  wire gfmix_pkg::column_t matrix_col,
  input  wire gfmix_pkg::matrix_t matrix,
  output gfmix_pkg::column_t      mixed
);
  import gfmix_pkg::*;

  for (genvar r = 0; r < MIX_BYTES; r++) begin : g_row
    always_comb begin : row_sum
      logic [BYTE_W-1:0] acc;
      acc = '0;
      for (int i = 0; i < MIX_BYTES; i++) begin
        acc = acc ^ gf_mul(matrix_col[i*BYTE_W +: BYTE_W], matrix[r][i*BYTE_W +: BYTE_W]);
      end
      mixed[r*BYTE_W +: BYTE_W] = acc;
    end
  end

endmodule
`default_nettype wire

// ----- design/gf256_mds_column_mix.sv -----
// Top level of the GF(2^8) MDS column mix: input register, mix, result register.
// An accepted request is captured in the input register, then its mixed result in the result register on out_valid.
// Throughput: one column per cycle while out_stall is low; the mix sits between the input and result registers.
// in_stall rises only while the input register is full and the result register is held.
// Reset (rst_n low, synchronous) empties both stages and clears all matrix rows to zero.
`timescale 1ns / 1ps
`default_nettype none
module gf256_mds_column_mix (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire gfmix_pkg::in_req_t    in_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output gfmix_pkg::out_req_t        out_data,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire gfmix_pkg::cfg_index_t cfg_index,
  input  wire gfmix_pkg::column_t    cfg_data
);
  import gfmix_pkg::*;

  matrix_t  matrix;
  column_t  mixed;

  logic     s1_valid_r;
  logic     s1_valid_nxt;
  in_req_t  s1_data_r;
  logic     out_valid_r;
  logic     out_valid_nxt;
  out_req_t out_data_r;
  logic     out_free;
  logic     in_take;
  logic     s1_move;

  assign cfg_ready = 1'b1;

  gfmix_regs u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid & cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .matrix    (matrix)
  );

  gfmix_mix u_mix (
    .matrix_col (s1_data_r.column_in),
    .matrix     (matrix),
    .mixed      (mixed)
  );

  always_comb begin
    out_free      = !out_valid_r || !out_stall;
    s1_move       = s1_valid_r && out_free;
    in_stall      = s1_valid_r && !out_free;
    in_take       = in_valid && !in_stall;
    s1_valid_nxt  = in_take || (s1_valid_r && !s1_move);
    out_valid_nxt = s1_move || (out_valid_r && !out_free);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // advance payload only on a move; hold otherwise
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_data_r <= in_data;
    end
    if (s1_move) begin
      out_data_r.column_out <= mixed;
      out_data_r.last       <= s1_data_r.last_column;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

// ----- design/gfmix_checker.sv -----
// Port-level checks for the column mix, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module gfmix_checker (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_stall,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire gfmix_pkg::out_req_t out_data
);
  import gfmix_pkg::*;

  a_out_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result request dropped while stalled");

  a_out_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_data))
    else $error("result payload changed while stalled");

  a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty result register");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind gf256_mds_column_mix gfmix_checker u_gfmix_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
`default_nettype wire
